// ----- rtl/hes_pkg.sv -----
// ----------------------------------------------------------------------------
// hes_pkg
// Shared types, constants and Hamming SEC functions for the ECC word store.
// ----------------------------------------------------------------------------
package hes_pkg;

	localparam int IDX_W           = 10;
	localparam int DATA_W          = 64;
	localparam int POS_W           = 7;
	localparam int SYN_W           = 7;
	localparam int PAR_MAX         = 7;
	localparam int CW_MAX          = 71;
	localparam int DEPTH_CMP_W     = 17;
	localparam int DEF_DATA_BITS   = 64;
	localparam int DEF_STORE_DEPTH = 1024;
	localparam int DEF_QUEUE_DEPTH = 2;

	typedef enum logic {
		REQ_WRITE = 1'b0,
		REQ_READ  = 1'b1
	} req_kind_t;

	// what the back end does with a queued beat
	typedef enum logic [1:0] {
		OP_WRITE,
		OP_READ,
		OP_SKIP
	} op_t;

	typedef struct packed {
		req_kind_t          req_type;
		logic [IDX_W-1:0]   word_index;
		logic [DATA_W-1:0]  write_data;
		logic               inject_enable;
		logic [POS_W-1:0]   inject_position;
	} req_item_t;

	typedef struct packed {
		logic [DATA_W-1:0]  read_data;
		logic               found;
		logic [SYN_W-1:0]   syndrome;
		logic               syndrome_out_of_range;
	} rsp_item_t;

	function automatic int parity_count(input int data_bits);
		int r;
		r = 0;
		for (int k = 0; k < PAR_MAX + 1; k++) begin
			if ((1 << r) < data_bits + r + 1) begin
				r++;
			end
		end
		return r;
	endfunction

	function automatic int mem_depth(input int store_depth);
		return (store_depth < (1 << IDX_W)) ? store_depth : (1 << IDX_W);
	endfunction

	function automatic int addr_width(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

	function automatic bit is_pow2(input int p);
		return (p != 0) && ((p & (p - 1)) == 0);
	endfunction

	// data bits fill the non power-of-two positions, then parity is set
	function automatic logic [CW_MAX-1:0] hamming_encode(input logic [DATA_W-1:0] data,
		input int data_bits);
		logic [CW_MAX-1:0] cw;
		logic              p;
		int                j;
		int                n;
		cw = '0;
		j  = 0;
		n  = data_bits + parity_count(data_bits);
		for (int pos = 1; pos <= CW_MAX; pos++) begin
			if (!is_pow2(pos)) begin
				if (j < data_bits) begin
					cw[pos-1] = data[j];
				end
				j++;
			end
		end
		for (int k = 0; k < PAR_MAX; k++) begin
			p = 1'b0;
			for (int pos = 1; pos <= CW_MAX; pos++) begin
				if ((((pos >> k) & 1) == 1) && !is_pow2(pos)) begin
					p = p ^ cw[pos-1];
				end
			end
			if ((1 << k) <= n) begin
				cw[(1 << k) - 1] = p;
			end
		end
		return cw;
	endfunction

	function automatic logic [SYN_W-1:0] hamming_syndrome(input logic [CW_MAX-1:0] cw);
		logic [SYN_W-1:0] syn;
		syn = '0;
		for (int pos = 1; pos <= CW_MAX; pos++) begin
			if (cw[pos-1]) begin
				syn = syn ^ SYN_W'(pos);
			end
		end
		return syn;
	endfunction

	function automatic logic [DATA_W-1:0] hamming_extract(input logic [CW_MAX-1:0] cw,
		input int data_bits);
		logic [DATA_W-1:0] data;
		int                j;
		data = '0;
		j    = 0;
		for (int pos = 1; pos <= CW_MAX; pos++) begin
			if (!is_pow2(pos)) begin
				if (j < data_bits) begin
					data[j] = cw[pos-1];
				end
				j++;
			end
		end
		return data;
	endfunction

endpackage

// ----- rtl/hes_front.sv -----
// ----------------------------------------------------------------------------
// hes_front
// Accepts request beats, classifies them and encodes write data into a
// Hamming codeword with optional single-bit injection.
// ----------------------------------------------------------------------------
module hes_front import hes_pkg::*; #(
	parameter int DATA_BITS   = DEF_DATA_BITS,
	parameter int STORE_DEPTH = DEF_STORE_DEPTH,
	parameter int ADDR_W      = addr_width(mem_depth(DEF_STORE_DEPTH)),
	parameter int CW_W        = DEF_DATA_BITS + parity_count(DEF_DATA_BITS),
	parameter int ENTRY_W     = $bits(op_t) + ADDR_W + CW_W
) (
	input  logic               req_valid,
	output logic               req_stall,
	input  req_item_t          req,
	input  logic               clearing,
	input  logic               q_full,
	output logic               push,
	output logic [ENTRY_W-1:0] push_entry
);

	typedef struct packed {
		op_t               op;
		logic [ADDR_W-1:0] addr;
		logic [CW_W-1:0]   cw;
	} entry_t;

	entry_t            entry;
	logic [CW_MAX-1:0] cw_full;
	logic [CW_MAX-1:0] flip;
	logic              in_range;

	always_comb begin
		flip = '0;
		for (int b = 0; b < CW_MAX; b++) begin
			flip[b] = (req.inject_position == POS_W'(b)) && (b < CW_W);
		end
		cw_full = hamming_encode(req.write_data, DATA_BITS);
		if (req.inject_enable) begin
			cw_full = cw_full ^ flip;
		end
		in_range = DEPTH_CMP_W'(req.word_index) < DEPTH_CMP_W'(STORE_DEPTH);
		if (!in_range) begin
			entry.op = OP_SKIP;
		end else if (req.req_type == REQ_WRITE) begin
			entry.op = OP_WRITE;
		end else begin
			entry.op = OP_READ;
		end
		entry.addr = req.word_index[ADDR_W-1:0];
		entry.cw   = cw_full[CW_W-1:0];
	end

	assign req_stall  = clearing || q_full;
	assign push       = req_valid && !req_stall;
	assign push_entry = entry;

endmodule

// ----- rtl/hes_queue.sv -----
// ----------------------------------------------------------------------------
// hes_queue
// Short FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module hes_queue import hes_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	output logic             pop_valid,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = count_q == CNT_W'(DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_data  = slot_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/hes_back.sv -----
// ----------------------------------------------------------------------------
// hes_back
// Codeword store with valid bit per entry, syndrome decode and single-bit
// correction, and the response register. Sweeps valid bits clear after reset.
// ----------------------------------------------------------------------------
module hes_back import hes_pkg::*; #(
	parameter int DATA_BITS = DEF_DATA_BITS,
	parameter int MEM_DEPTH = mem_depth(DEF_STORE_DEPTH),
	parameter int ADDR_W    = addr_width(mem_depth(DEF_STORE_DEPTH)),
	parameter int CW_W      = DEF_DATA_BITS + parity_count(DEF_DATA_BITS),
	parameter int ENTRY_W   = $bits(op_t) + ADDR_W + CW_W
) (
	input  logic               clk,
	input  logic               arst_n,
	output logic               clearing,
	input  logic               q_valid,
	output logic               q_pop,
	input  logic [ENTRY_W-1:0] q_data,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output rsp_item_t          rsp
);

	typedef struct packed {
		op_t               op;
		logic [ADDR_W-1:0] addr;
		logic [CW_W-1:0]   cw;
	} entry_t;

	// top bit of each word is the entry valid flag
	logic [CW_W:0]       mem [MEM_DEPTH];
	logic [CW_W:0]       rd_s1;
	op_t                 op_s1;
	logic                valid_s1;
	logic                clr_active_q;
	logic [ADDR_W-1:0]   clr_addr_q;
	logic                rsp_valid_q;
	rsp_item_t           rsp_q;
	entry_t              head;
	logic                adv_s1;
	rsp_item_t           result;
	logic [CW_MAX-1:0]   cw_full;
	logic [CW_MAX-1:0]   fix;
	logic [SYN_W-1:0]    syn;

	assign head     = q_data;
	assign clearing = clr_active_q;
	assign adv_s1   = !rsp_valid_q || !rsp_stall;
	assign q_pop    = q_valid && !clr_active_q && (!valid_s1 || adv_s1);

	always_ff @(posedge clk) begin
		if (clr_active_q) begin
			mem[clr_addr_q] <= '0;
		end else if (q_pop && head.op == OP_WRITE) begin
			mem[head.addr] <= {1'b1, head.cw};
		end
		if (q_pop) begin
			rd_s1 <= mem[head.addr];
			op_s1 <= head.op;
		end
	end

	always_comb begin
		cw_full = CW_MAX'(rd_s1[CW_W-1:0]);
		syn     = hamming_syndrome(cw_full);
		fix     = '0;
		for (int b = 0; b < CW_MAX; b++) begin
			fix[b] = (syn == SYN_W'(b + 1)) && (b < CW_W);
		end
		result = '0;
		if (op_s1 == OP_READ && rd_s1[CW_W]) begin
			result.read_data             = hamming_extract(cw_full ^ fix, DATA_BITS);
			result.found                 = 1'b1;
			result.syndrome              = syn;
			result.syndrome_out_of_range = syn > SYN_W'(CW_W);
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s1) begin
			rsp_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
			valid_s1     <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (clr_active_q) begin
				if (clr_addr_q == ADDR_W'(MEM_DEPTH - 1)) begin
					clr_active_q <= 1'b0;
				end else begin
					clr_addr_q <= clr_addr_q + 1'b1;
				end
			end
			if (q_pop) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				rsp_valid_q <= valid_s1;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- rtl/hamming_ecc_word_store.sv -----
// ----------------------------------------------------------------------------
// hamming_ecc_word_store
// Word store protected by a Hamming single-error-correcting code: writes are
// encoded (with optional one-bit injection) and stored, reads are corrected.
//
//   channel  dir  handshake             beat
//   req      in   req_valid/req_stall   req_item_t (write or read request)
//   rsp      out  rsp_valid/rsp_stall   rsp_item_t (one per request)
//
// Sustained rate is one beat per cycle while rsp_stall is low and no clearing
// pass runs; an accepted request passes the queue, the store read and the decode
// into the response reg before response valid. After reset a clearing pass writes
// all min(STORE_DEPTH, 1024) store words invalid, one per cycle; req_stall is high
// throughout. A stalled response holds the decode stage, the queue fills and then
// req_stall rises; a write followed by a read of the same index sees the data.
// ----------------------------------------------------------------------------
module hamming_ecc_word_store import hes_pkg::*; #(
	parameter int DATA_BITS   = DEF_DATA_BITS,
	parameter int STORE_DEPTH = DEF_STORE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp
);

	localparam int MEM_DEPTH = mem_depth(STORE_DEPTH);
	localparam int ADDR_W    = addr_width(MEM_DEPTH);
	localparam int CW_W      = DATA_BITS + parity_count(DATA_BITS);
	localparam int ENTRY_W   = $bits(op_t) + ADDR_W + CW_W;

	logic               clearing;
	logic               q_full;
	logic               push;
	logic [ENTRY_W-1:0] push_entry;
	logic               q_valid;
	logic               q_pop;
	logic [ENTRY_W-1:0] q_data;

	hes_front #(
		.DATA_BITS  (DATA_BITS),
		.STORE_DEPTH(STORE_DEPTH),
		.ADDR_W     (ADDR_W),
		.CW_W       (CW_W),
		.ENTRY_W    (ENTRY_W)
	) u_front (
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.clearing  (clearing),
		.q_full    (q_full),
		.push      (push),
		.push_entry(push_entry)
	);

	hes_queue #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEF_QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_entry),
		.full     (q_full),
		.pop_valid(q_valid),
		.pop      (q_pop),
		.pop_data (q_data)
	);

	hes_back #(
		.DATA_BITS(DATA_BITS),
		.MEM_DEPTH(MEM_DEPTH),
		.ADDR_W   (ADDR_W),
		.CW_W     (CW_W),
		.ENTRY_W  (ENTRY_W)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.clearing (clearing),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_data   (q_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

endmodule

// ----- test/hamming_ecc_word_store_tb.sv -----
// ----------------------------------------------------------------------------
// hamming_ecc_word_store_tb
// Writes Hamming-coded words, with and without a single injected bit error,
// reads them back and checks every response field against a scoreboard that
// keeps its own copy of the coded store. Both channels idle at random.
// ----------------------------------------------------------------------------
module hamming_ecc_word_store_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import hes_pkg::*;

	localparam int RANDOM_ITEMS = 1950;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int IDLE_PCT     = 16;

	class ecc_store_scoreboard;
		logic [CW_MAX-1:0] code_mem [DEF_STORE_DEPTH];
		bit                word_valid [DEF_STORE_DEPTH];
		rsp_item_t         pending_rsp [$];
		int                errors;

		function new();
			errors = 0;
			foreach (word_valid[i]) begin
				word_valid[i] = 1'b0;
			end
		endfunction

		// expected response for one accepted request beat
		function void accept_request(input req_item_t r);
			logic [CW_MAX-1:0] cw;
			logic [SYN_W-1:0]  syn;
			logic [DATA_W-1:0] data;
			rsp_item_t         exp_rsp;
			int                pos;
			int                j;
			int                k;
			exp_rsp = '0;
			if (r.req_type == REQ_WRITE) begin
				cw  = '0;
				syn = '0;
				j   = 0;
				for (pos = 1; pos <= CW_MAX; pos++) begin
					if ((pos & (pos - 1)) != 0) begin
						if (r.write_data[j]) begin
							cw[pos-1] = 1'b1;
							syn = syn ^ SYN_W'(pos);
						end
						j++;
					end
				end
				// parity bits cancel the data syndrome
				for (k = 0; k < SYN_W; k++) begin
					if (syn[k]) begin
						cw[(1 << k) - 1] = ~cw[(1 << k) - 1];
					end
				end
				if (r.inject_enable && r.inject_position < CW_MAX) begin
					cw[r.inject_position] = ~cw[r.inject_position];
				end
				code_mem[r.word_index]   = cw;
				word_valid[r.word_index] = 1'b1;
			end else if (word_valid[r.word_index]) begin
				cw  = code_mem[r.word_index];
				syn = '0;
				for (pos = 1; pos <= CW_MAX; pos++) begin
					if (cw[pos-1]) begin
						syn = syn ^ SYN_W'(pos);
					end
				end
				if (syn != 0 && syn <= CW_MAX) begin
					cw[syn-1] = ~cw[syn-1];
				end
				data = '0;
				j    = 0;
				for (pos = 1; pos <= CW_MAX; pos++) begin
					if ((pos & (pos - 1)) != 0) begin
						data[j] = cw[pos-1];
						j++;
					end
				end
				exp_rsp.read_data             = data;
				exp_rsp.found                 = 1'b1;
				exp_rsp.syndrome              = syn;
				exp_rsp.syndrome_out_of_range = (syn > CW_MAX);
			end
			pending_rsp = {pending_rsp, exp_rsp};
		endfunction

		task report(input string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_response(input rsp_item_t got);
			rsp_item_t exp_rsp;
			if (pending_rsp.size() == 0) begin
				report($sformatf("response with nothing pending: %h", got));
			end else begin
				exp_rsp = pending_rsp.pop_front();
				if (got.read_data !== exp_rsp.read_data) begin
					report($sformatf("read_data got %h exp %h", got.read_data,
						exp_rsp.read_data));
				end
				if (got.found !== exp_rsp.found) begin
					report($sformatf("found got %b exp %b", got.found, exp_rsp.found));
				end
				if (got.syndrome !== exp_rsp.syndrome) begin
					report($sformatf("syndrome got %0d exp %0d", got.syndrome,
						exp_rsp.syndrome));
				end
				if (got.syndrome_out_of_range !== exp_rsp.syndrome_out_of_range) begin
					report($sformatf("syndrome_out_of_range got %b exp %b",
						got.syndrome_out_of_range, exp_rsp.syndrome_out_of_range));
				end
			end
		endtask
	endclass

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	req_item_t req;
	logic      rsp_valid;
	logic      rsp_stall;
	rsp_item_t rsp;

	ecc_store_scoreboard sb;
	bit                  idle_en;
	bit                  stall_en;
	int                  cycle_count = 0;
	bit                  was_written [DEF_STORE_DEPTH];
	int                  written_idx [$];
	int                  last_written;

	hamming_ecc_word_store dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(negedge clk) begin
		rsp_stall <= stall_en && ($urandom_range(0, 99) < IDLE_PCT);
	end

	// responses first so a beat accepted this edge never matches itself
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				sb.check_response(rsp);
			end
			if (req_valid && !req_stall) begin
				sb.accept_request(req);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// entered and left at a falling edge
	task send_item(input req_item_t it);
		while (idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req       <= it;
		req_valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (req_stall);
		@(negedge clk);
	endtask

	task send_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data,
		input logic inj_en, input logic [POS_W-1:0] inj_pos);
		req_item_t it;
		it.req_type        = REQ_WRITE;
		it.word_index      = idx;
		it.write_data      = data;
		it.inject_enable   = inj_en;
		it.inject_position = inj_pos;
		if (!was_written[idx]) begin
			was_written[idx] = 1'b1;
			written_idx = {written_idx, int'(idx)};
		end
		last_written = int'(idx);
		send_item(it);
	endtask

	// unused fields of a read carry noise
	task send_read(input logic [IDX_W-1:0] idx);
		req_item_t it;
		it.req_type        = REQ_READ;
		it.word_index      = idx;
		it.write_data      = {$urandom, $urandom};
		it.inject_enable   = 1'($urandom_range(0, 1));
		it.inject_position = POS_W'($urandom_range(0, 127));
		send_item(it);
	endtask

	task drain;
		req_valid <= 1'b0;
		do begin
			@(negedge clk);
		end while (sb.pending_rsp.size() != 0);
	endtask

	initial begin
		logic [DATA_W-1:0] data;
		logic [POS_W-1:0]  pos;
		logic [IDX_W-1:0]  idx;
		sb        = new();
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		idle_en   = 1'b1;
		stall_en  = 1'b1;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		send_write(10'd0, '0, 1'b0, 7'd0);
		send_read(10'd0);
		send_write(10'd1023, '1, 1'b0, 7'd0);
		send_read(10'd1023);
		// error on the first parity bit
		send_write(10'd1, 64'h0123_4567_89ab_cdef, 1'b1, 7'd0);
		send_read(10'd1);
		// error on the last data bit
		send_write(10'd2, 64'hfedc_ba98_7654_3210, 1'b1, 7'd70);
		send_read(10'd2);
		// error on the top parity bit
		send_write(10'd3, 64'h8000_0000_0000_0001, 1'b1, 7'd63);
		send_read(10'd3);
		// positions past the codeword flip nothing
		send_write(10'd4, 64'h5555_aaaa_5555_aaaa, 1'b1, 7'd71);
		send_read(10'd4);
		send_write(10'd5, 64'haaaa_5555_aaaa_5555, 1'b1, 7'd127);
		send_read(10'd5);
		send_write(10'd6, 64'hdead_beef_cafe_f00d, 1'b0, 7'd9);
		send_read(10'd6);
		// overwrite index 0 and read it back, then read index 1023 again
		send_write(10'd0, '1, 1'b1, 7'd5);
		send_read(10'd0);
		send_read(10'd1023);
		drain();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			idle_en  = !(i >= 700 && i < 1000);
			stall_en = !(i >= 700 && i < 1000);
			if (i == 1300) begin
				drain();
			end
			if (written_idx.size() == 0 || $urandom_range(0, 1) == 0) begin
				// mostly a small window so reads often follow writes closely
				idx = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom_range(0, 1023))
					: IDX_W'($urandom_range(0, 31));
				case ($urandom_range(0, 9))
					0: data = '0;
					1: data = '1;
					default: data = {$urandom, $urandom};
				endcase
				pos = ($urandom_range(0, 4) == 0) ? POS_W'($urandom_range(0, 127))
					: POS_W'($urandom_range(0, CW_MAX - 1));
				send_write(idx, data, 1'($urandom_range(0, 1)), pos);
			end else if ($urandom_range(0, 1) == 0) begin
				send_read(IDX_W'(last_written));
			end else begin
				send_read(IDX_W'(written_idx[$urandom_range(0, written_idx.size() - 1)]));
			end
		end
		drain();
		repeat (10) @(posedge clk);
		if (sb.errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/hes_pkg.sv
rtl/hes_front.sv
rtl/hes_queue.sv
rtl/hes_back.sv
rtl/hamming_ecc_word_store.sv
test/hamming_ecc_word_store_tb.sv
